[rtl/sdd_pkg.sv]
// Shared types and constants of the swipe direction decoder.
`timescale 1ns / 1ps

package sdd_pkg;

  localparam int LEVEL_W    = 8;
  localparam int THR_W      = 7;
  localparam int DIR_W      = 3;
  localparam int DIVIDEND_W = 15;
  localparam int DIVISOR_W  = 9;
  localparam int QUOT_W     = 7;
  localparam int ASYM_W     = 8;

  localparam logic [LEVEL_W-1:0] LEVEL_SATURATED = 8'd255;
  localparam logic [6:0]         PERCENT_SCALE   = 7'd100;
  localparam logic [THR_W-1:0]   THR_RESET       = 7'd30;
  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RESET = 8'd30;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_MIN_LEVEL = 1'b1;

  localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;

  typedef struct packed {
    logic [LEVEL_W-1:0] up;
    logic [LEVEL_W-1:0] down;
    logic [LEVEL_W-1:0] left;
    logic [LEVEL_W-1:0] right;
  } sample_t;

  typedef struct packed {
    sample_t first;
    sample_t latest;
    logic    enough;
  } job_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/sdd_front.sv]
// Sample qualification and first/latest capture; emits one job per gesture.
`timescale 1ns / 1ps

module sdd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [sdd_pkg::LEVEL_W-1:0]  up_level,
  input  logic [sdd_pkg::LEVEL_W-1:0]  down_level,
  input  logic [sdd_pkg::LEVEL_W-1:0]  left_level,
  input  logic [sdd_pkg::LEVEL_W-1:0]  right_level,
  input  logic                         end_of_gesture,
  input  logic [sdd_pkg::LEVEL_W-1:0]  min_level,
  output logic                         job_push,
  output sdd_pkg::job_t                job
);

  sdd_pkg::sample_t first_r, first_nxt;
  sdd_pkg::sample_t latest_r, latest_nxt;
  logic [1:0]       seen_r, seen_nxt;
  logic             sample_ok;

  always_comb begin
    sample_ok = !(up_level == sdd_pkg::LEVEL_SATURATED ||
                  down_level == sdd_pkg::LEVEL_SATURATED ||
                  left_level == sdd_pkg::LEVEL_SATURATED ||
                  right_level == sdd_pkg::LEVEL_SATURATED) &&
                up_level >= min_level && down_level >= min_level &&
                left_level >= min_level && right_level >= min_level;

    first_nxt  = first_r;
    latest_nxt = latest_r;
    seen_nxt   = seen_r;
    if (sample_ok) begin
      if (seen_r == 2'd0) begin
        first_nxt = '{up_level, down_level, left_level, right_level};
      end
      latest_nxt = '{up_level, down_level, left_level, right_level};
      if (seen_r != 2'd2) begin
        seen_nxt = seen_r + 2'd1;
      end
    end

    job_push   = accept && end_of_gesture;
    job.first  = first_nxt;
    job.latest = latest_nxt;
    job.enough = (seen_nxt == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
    end else if (accept) begin
      seen_r <= end_of_gesture ? 2'd0 : seen_nxt;
    end
  end

  // The kept samples are only read once the count says they are valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      first_r  <= first_nxt;
      latest_r <= latest_nxt;
    end
  end

endmodule

[rtl/sdd_job_queue.sv]
// Short queue of gesture jobs between the front and the back.
`timescale 1ns / 1ps

module sdd_job_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sdd_pkg::job_t push_job,
  input  logic          pop,
  output sdd_pkg::job_t pop_job,
  output logic          full,
  output logic          empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sdd_pkg::job_t    store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("job queue count beyond depth");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("job queue count did not follow a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> wr_ptr_r == rd_ptr_r)
    else $error("job queue pointers disagree with count");

endmodule

[rtl/sdd_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module sdd_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sdd_pkg::div_req_t req,
  output sdd_pkg::div_rsp_t rsp
);

  localparam int STEPS = sdd_pkg::DIVIDEND_W;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [sdd_pkg::DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [sdd_pkg::DIVIDEND_W-1:0] q_r, q_nxt;
  logic [sdd_pkg::DIVISOR_W-1:0]  divisor_r, divisor_nxt;
  logic [sdd_pkg::DIVISOR_W:0]    trial;

  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    q_nxt       = q_r;
    divisor_nxt = divisor_r;
    trial       = {rem_r, q_r[sdd_pkg::DIVIDEND_W-1]};
    if (req.start && !busy_r) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = '0;
      rem_nxt     = '0;
      q_nxt       = req.dividend;
      divisor_nxt = req.divisor;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so the difference fits.
      if (trial >= {1'b0, divisor_r}) begin
        rem_nxt = sdd_pkg::DIVISOR_W'(trial - {1'b0, divisor_r});
        q_nxt   = {q_r[sdd_pkg::DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[sdd_pkg::DIVISOR_W-1:0];
        q_nxt   = {q_r[sdd_pkg::DIVIDEND_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    divisor_r <= divisor_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = q_r[sdd_pkg::QUOT_W-1:0];

endmodule

[rtl/sdd_back.sv]
// Per-gesture sequencer: up to four asymmetry divisions, the decision and the result register.
`timescale 1ns / 1ps

module sdd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        job_empty,
  input  sdd_pkg::job_t               job,
  output logic                        job_pop,
  input  logic [sdd_pkg::THR_W-1:0]   threshold,
  output sdd_pkg::div_req_t           div_req,
  input  sdd_pkg::div_rsp_t           div_rsp,
  input  logic                        out_pop,
  output logic                        out_empty,
  output logic [sdd_pkg::DIR_W-1:0]   out_direction
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  localparam logic [1:0] AX_ZERO  = 2'd0;
  localparam logic [1:0] AX_PLUS  = 2'd1;
  localparam logic [1:0] AX_MINUS = 2'd2;

  localparam int DW = sdd_pkg::ASYM_W + 1;

  logic [2:0]                    state_r, state_nxt;
  logic [1:0]                    k_r, k_nxt;
  sdd_pkg::job_t                 job_r;
  logic signed [sdd_pkg::ASYM_W-1:0] asym_r [4];
  logic                          neg_r, neg_nxt;
  logic [sdd_pkg::DIR_W-1:0]     dir_r, dir_nxt;
  logic                          out_valid_r;
  logic [sdd_pkg::DIR_W-1:0]     out_dir_r;

  logic [sdd_pkg::LEVEL_W-1:0]   op_a, op_b, mag;
  logic [sdd_pkg::DIVISOR_W-1:0] sum;
  logic                          asym_we;
  logic signed [sdd_pkg::ASYM_W-1:0] asym_val, q_ext;
  logic                          out_load;

  logic signed [DW-1:0] d_ud, d_lr, t_pos, t_neg;
  logic [DW-1:0]        abs_ud, abs_lr;
  logic [1:0]           s_ud, s_lr;
  logic [sdd_pkg::DIR_W-1:0] dir_dec;

  // Operand order: first sample up/down, first left/right, then the latest sample.
  always_comb begin
    case (k_r)
      2'd0: begin op_a = job_r.first.up;    op_b = job_r.first.down;   end
      2'd1: begin op_a = job_r.first.left;  op_b = job_r.first.right;  end
      2'd2: begin op_a = job_r.latest.up;   op_b = job_r.latest.down;  end
      default: begin op_a = job_r.latest.left; op_b = job_r.latest.right; end
    endcase
    mag = (op_a >= op_b) ? op_a - op_b : op_b - op_a;
    sum = {1'b0, op_a} + {1'b0, op_b};
  end

  assign div_req.dividend = sdd_pkg::DIVIDEND_W'({7'd0, mag}) *
                            sdd_pkg::DIVIDEND_W'(sdd_pkg::PERCENT_SCALE);
  assign div_req.divisor  = sum;
  assign div_req.start    = (state_r == S_LOAD) && (sum != '0);

  assign q_ext = {1'b0, div_rsp.quotient};

  // Axis decision on the differences of the stored asymmetries.
  always_comb begin
    d_ud   = DW'({asym_r[2][sdd_pkg::ASYM_W-1], asym_r[2]} -
                 {asym_r[0][sdd_pkg::ASYM_W-1], asym_r[0]});
    d_lr   = DW'({asym_r[3][sdd_pkg::ASYM_W-1], asym_r[3]} -
                 {asym_r[1][sdd_pkg::ASYM_W-1], asym_r[1]});
    t_pos  = {2'b00, threshold};
    t_neg  = -t_pos;
    abs_ud = d_ud[DW-1] ? DW'(-d_ud) : d_ud;
    abs_lr = d_lr[DW-1] ? DW'(-d_lr) : d_lr;
    s_ud = (d_ud >= t_pos) ? AX_PLUS : ((d_ud <= t_neg) ? AX_MINUS : AX_ZERO);
    s_lr = (d_lr >= t_pos) ? AX_PLUS : ((d_lr <= t_neg) ? AX_MINUS : AX_ZERO);
    if (s_ud == AX_MINUS && s_lr == AX_ZERO) begin
      dir_dec = sdd_pkg::DIR_UP;
    end else if (s_ud == AX_PLUS && s_lr == AX_ZERO) begin
      dir_dec = sdd_pkg::DIR_DOWN;
    end else if (s_ud == AX_ZERO && s_lr == AX_MINUS) begin
      dir_dec = sdd_pkg::DIR_LEFT;
    end else if (s_ud == AX_ZERO && s_lr == AX_PLUS) begin
      dir_dec = sdd_pkg::DIR_RIGHT;
    end else if (abs_ud > abs_lr) begin
      dir_dec = (s_ud == AX_MINUS) ? sdd_pkg::DIR_UP : sdd_pkg::DIR_DOWN;
    end else begin
      dir_dec = (s_lr == AX_MINUS) ? sdd_pkg::DIR_LEFT : sdd_pkg::DIR_RIGHT;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    neg_nxt   = neg_r;
    dir_nxt   = dir_r;
    job_pop   = 1'b0;
    asym_we   = 1'b0;
    asym_val  = '0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!job_empty) begin
          job_pop = 1'b1;
          k_nxt   = 2'd0;
          if (job.enough) begin
            state_nxt = S_LOAD;
          end else begin
            dir_nxt   = sdd_pkg::DIR_NONE;
            state_nxt = S_OUT;
          end
        end
      end
      S_LOAD: begin
        neg_nxt = (op_a < op_b);
        if (sum == '0) begin
          // Both channels dark: the asymmetry counts as zero.
          asym_we   = 1'b1;
          k_nxt     = k_r + 2'd1;
          state_nxt = (k_r == 2'd3) ? S_DECIDE : S_LOAD;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          asym_we   = 1'b1;
          asym_val  = neg_r ? sdd_pkg::ASYM_W'(-q_ext) : q_ext;
          k_nxt     = k_r + 2'd1;
          state_nxt = (k_r == 2'd3) ? S_DECIDE : S_LOAD;
        end
      end
      S_DECIDE: begin
        dir_nxt   = dir_dec;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_pop) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    neg_r <= neg_nxt;
    dir_r <= dir_nxt;
    if (job_pop) begin
      job_r <= job;
    end
    if (asym_we) begin
      asym_r[k_r] <= asym_val;
    end
    if (out_load) begin
      out_dir_r <= dir_r;
    end
  end

  assign out_empty     = !out_valid_r;
  assign out_direction = out_dir_r;

  a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting on a divider that is not running");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
  a_decide_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |-> $past(k_r) == 2'd3)
    else $error("decision before all four asymmetries");
  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_dir_r <= sdd_pkg::DIR_RIGHT)
    else $error("direction code out of range");

endmodule

[rtl/swipe_direction_decoder.sv]
// Top level: configuration registers, front, job queue, divider and back.
// Samples are taken one per clock; an item is held only while the job queue is full.
// The direction of a gesture is set by up to four 15-step divisions in one shared divider;
// with fewer than two valid samples no division runs and the direction is none.
// The back decodes one gesture at a time; JOB_DEPTH end marks can wait in the job queue.
// Reset (synchronous, rst_n low) sets threshold and minimum level to 30 and clears control state only.
`timescale 1ns / 1ps

module swipe_direction_decoder #(
  parameter int JOB_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [sdd_pkg::LEVEL_W-1:0] in_up_level,
  input  logic [sdd_pkg::LEVEL_W-1:0] in_down_level,
  input  logic [sdd_pkg::LEVEL_W-1:0] in_left_level,
  input  logic [sdd_pkg::LEVEL_W-1:0] in_right_level,
  input  logic                        in_end_of_gesture,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [sdd_pkg::DIR_W-1:0]   out_direction,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [sdd_pkg::LEVEL_W-1:0] cfg_data
);

  logic [sdd_pkg::THR_W-1:0]   threshold_r;
  logic [sdd_pkg::LEVEL_W-1:0] min_level_r;
  logic                        accept;
  logic                        job_push, job_pop, job_empty;
  sdd_pkg::job_t               push_job, pop_job;
  sdd_pkg::div_req_t           div_req;
  sdd_pkg::div_rsp_t           div_rsp;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= sdd_pkg::THR_RESET;
      min_level_r <= sdd_pkg::MIN_LEVEL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        sdd_pkg::CFG_THRESHOLD: threshold_r <= cfg_data[sdd_pkg::THR_W-1:0];
        sdd_pkg::CFG_MIN_LEVEL: min_level_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sdd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .up_level       (in_up_level),
    .down_level     (in_down_level),
    .left_level     (in_left_level),
    .right_level    (in_right_level),
    .end_of_gesture (in_end_of_gesture),
    .min_level      (min_level_r),
    .job_push       (job_push),
    .job            (push_job)
  );

  sdd_job_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .pop_job  (pop_job),
    .full     (in_full),
    .empty    (job_empty)
  );

  sdd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  sdd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_empty     (job_empty),
    .job           (pop_job),
    .job_pop       (job_pop),
    .threshold     (threshold_r),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_direction (out_direction)
  );

endmodule

[dv/swipe_direction_decoder_tb.sv]
// Self-checking testbench of the swipe direction decoder: a directed table, then random gestures.
`timescale 1ns / 1ps

module swipe_direction_decoder_tb;

  localparam int DRAIN_CYCLES    = 100;
  localparam int STALL_LIMIT     = 4000;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int NUM_PHASES      = 8;
  localparam int N_ROWS          = 25;
  localparam int ROW_LOOSE_CFG   = 18;
  localparam int ROW_DARK_CFG    = 23;

  typedef struct {
    logic [sdd_pkg::LEVEL_W-1:0] up, down, left, right;
    logic                        eog;
    logic                        typed;
    logic [sdd_pkg::DIR_W-1:0]   dir;
  } stim_row_t;

  logic                        clk               = 1'b0;
  logic                        rst_n             = 1'b0;
  logic                        in_push           = 1'b0;
  logic                        in_full;
  logic [sdd_pkg::LEVEL_W-1:0] in_up_level       = '0;
  logic [sdd_pkg::LEVEL_W-1:0] in_down_level     = '0;
  logic [sdd_pkg::LEVEL_W-1:0] in_left_level     = '0;
  logic [sdd_pkg::LEVEL_W-1:0] in_right_level    = '0;
  logic                        in_end_of_gesture = 1'b0;
  logic                        out_empty;
  logic                        out_pop           = 1'b0;
  logic [sdd_pkg::DIR_W-1:0]   out_direction;
  logic                        cfg_valid         = 1'b0;
  logic                        cfg_ready;
  logic                        cfg_index         = sdd_pkg::CFG_THRESHOLD;
  logic [sdd_pkg::LEVEL_W-1:0] cfg_data          = '0;

  // Travels with each item: a direction written into the table instead of predicted.
  logic                        row_typed = 1'b0;
  logic [sdd_pkg::DIR_W-1:0]   row_dir   = sdd_pkg::DIR_NONE;

  // Predictor copy of the gesture state and the registers.
  sdd_pkg::sample_t            first_s   = '0;
  sdd_pkg::sample_t            latest_s  = '0;
  logic [1:0]                  seen      = 2'd0;
  logic [sdd_pkg::THR_W-1:0]   thr_reg   = sdd_pkg::THR_RESET;
  logic [sdd_pkg::LEVEL_W-1:0] min_reg   = sdd_pkg::MIN_LEVEL_RESET;
  logic [sdd_pkg::DIR_W-1:0]   pending_dirs[$];

  int mismatches  = 0;
  int gestures    = 0;
  int items_sent  = 0;
  int cfg_writes  = 0;
  int idle_cycles = 0;
  int send_idle   = 0;
  int recv_stall  = 0;
  int cur_min     = 30;
  int dir_count[5] = '{0, 0, 0, 0, 0};
  int phase_thr[NUM_PHASES] = '{0, 100, 45, 100, 1, 60, 7, 30};
  int phase_min[NUM_PHASES] = '{0, 255, 10, 0, 200, 40, 90, 30};

  swipe_direction_decoder DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_up_level       (in_up_level),
    .in_down_level     (in_down_level),
    .in_left_level     (in_left_level),
    .in_right_level    (in_right_level),
    .in_end_of_gesture (in_end_of_gesture),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_direction     (out_direction),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int percent_asym(logic [sdd_pkg::LEVEL_W-1:0] a,
                                      logic [sdd_pkg::LEVEL_W-1:0] b);
    int sum;
    sum = int'(a) + int'(b);
    if (sum == 0) return 0;
    return ((int'(a) - int'(b)) * 100) / sum;
  endfunction

  function automatic int axis_move(int delta, int t);
    if (delta >= t) return 1;
    if (delta <= -t) return -1;
    return 0;
  endfunction

  function automatic logic [sdd_pkg::DIR_W-1:0] gesture_direction(
    sdd_pkg::sample_t f, sdd_pkg::sample_t l, logic [1:0] n, logic [sdd_pkg::THR_W-1:0] thr);
    int t, d_ud, d_lr, s_ud, s_lr, a_ud, a_lr;
    if (n < 2'd2) return sdd_pkg::DIR_NONE;
    t    = int'(thr);
    d_ud = percent_asym(l.up, l.down) - percent_asym(f.up, f.down);
    d_lr = percent_asym(l.left, l.right) - percent_asym(f.left, f.right);
    s_ud = axis_move(d_ud, t);
    s_lr = axis_move(d_lr, t);
    if (s_ud == -1 && s_lr == 0) return sdd_pkg::DIR_UP;
    if (s_ud == 1 && s_lr == 0) return sdd_pkg::DIR_DOWN;
    if (s_ud == 0 && s_lr == -1) return sdd_pkg::DIR_LEFT;
    if (s_ud == 0 && s_lr == 1) return sdd_pkg::DIR_RIGHT;
    a_ud = (d_ud < 0) ? -d_ud : d_ud;
    a_lr = (d_lr < 0) ? -d_lr : d_lr;
    if (a_ud > a_lr) return (s_ud == -1) ? sdd_pkg::DIR_UP : sdd_pkg::DIR_DOWN;
    return (s_lr == -1) ? sdd_pkg::DIR_LEFT : sdd_pkg::DIR_RIGHT;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Monitor: sample handshakes at the edge, update the predictor and check results.
  always @(posedge clk) begin
    sdd_pkg::sample_t          s;
    logic [sdd_pkg::DIR_W-1:0] dir;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sdd_pkg::CFG_THRESHOLD) thr_reg = cfg_data[sdd_pkg::THR_W-1:0];
        else min_reg = cfg_data;
        cfg_writes++;
      end
      if (in_push && !in_full) begin
        s = '{up: in_up_level, down: in_down_level, left: in_left_level, right: in_right_level};
        if (s.up != sdd_pkg::LEVEL_SATURATED && s.down != sdd_pkg::LEVEL_SATURATED &&
            s.left != sdd_pkg::LEVEL_SATURATED && s.right != sdd_pkg::LEVEL_SATURATED &&
            s.up >= min_reg && s.down >= min_reg && s.left >= min_reg && s.right >= min_reg) begin
          if (seen == 2'd0) first_s = s;
          latest_s = s;
          if (seen < 2'd2) seen++;
        end
        if (in_end_of_gesture) begin
          dir = row_typed ? row_dir : gesture_direction(first_s, latest_s, seen, thr_reg);
          pending_dirs.push_back(dir);
          first_s  = '0;
          latest_s = '0;
          seen     = 2'd0;
          gestures++;
        end
      end
      if (out_pop && !out_empty) begin
        if (pending_dirs.size() == 0) begin
          report_mismatch($sformatf("direction %0d with no gesture waiting", out_direction));
        end else begin
          dir = pending_dirs.pop_front();
          if (out_direction !== dir)
            report_mismatch($sformatf("direction %0d, expected %0d", out_direction, dir));
          if (out_direction < 5) dir_count[out_direction]++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_pop <= ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_item(logic [sdd_pkg::LEVEL_W-1:0] u, logic [sdd_pkg::LEVEL_W-1:0] d,
                           logic [sdd_pkg::LEVEL_W-1:0] l, logic [sdd_pkg::LEVEL_W-1:0] r,
                           logic eog, logic typed, logic [sdd_pkg::DIR_W-1:0] dir);
    while ($urandom_range(0, 99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_up_level       <= u;
    in_down_level     <= d;
    in_left_level     <= l;
    in_right_level    <= r;
    in_end_of_gesture <= eog;
    row_typed         <= typed;
    row_dir           <= dir;
    in_push           <= 1'b1;
    do @(posedge clk); while (in_full !== 1'b0);
    items_sent++;
  endtask

  task automatic wait_results();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_dirs.size() != 0) @(posedge clk);
  endtask

  // Every direction is out; leave a quiet stretch before the registers change.
  task automatic quiesce();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(int thr, int min_lvl);
    cfg_index <= sdd_pkg::CFG_THRESHOLD;
    cfg_data  <= sdd_pkg::LEVEL_W'(thr);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_index <= sdd_pkg::CFG_MIN_LEVEL;
    cfg_data  <= sdd_pkg::LEVEL_W'(min_lvl);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cur_min = min_lvl;
  endtask

  function automatic logic [sdd_pkg::LEVEL_W-1:0] clean_level();
    if (cur_min > 254) return sdd_pkg::LEVEL_SATURATED;
    return sdd_pkg::LEVEL_W'($urandom_range(cur_min, 254));
  endfunction

  function automatic logic [sdd_pkg::LEVEL_W-1:0] noise_level();
    if (cur_min == 0 || $urandom_range(0, 1) == 0) return sdd_pkg::LEVEL_SATURATED;
    return sdd_pkg::LEVEL_W'($urandom_range(0, cur_min - 1));
  endfunction

  task automatic random_gesture();
    int                          len, k, c;
    logic [sdd_pkg::LEVEL_W-1:0] lv[4];
    len = $urandom_range(1, 7);
    if ($urandom_range(0, 19) == 0) len = $urandom_range(8, 20);
    for (k = 0; k < len; k++) begin
      for (c = 0; c < 4; c++) lv[c] = clean_level();
      // Balanced samples give zero asymmetry on both axes.
      if ($urandom_range(0, 9) == 0) for (c = 1; c < 4; c++) lv[c] = lv[0];
      if ($urandom_range(0, 4) == 0) lv[$urandom_range(0, 3)] = noise_level();
      push_item(lv[0], lv[1], lv[2], lv[3], k == len - 1, 1'b0, sdd_pkg::DIR_NONE);
    end
  endtask

  initial begin
    stim_row_t rows[N_ROWS];
    int        i, p, start;
    rows[0]  = '{100, 100, 100, 100, 1'b1, 1'b1, sdd_pkg::DIR_NONE};
    rows[1]  = '{255, 100, 100, 100, 1'b0, 1'b0, sdd_pkg::DIR_NONE};
    rows[2]  = '{100,  29, 100, 100, 1'b0, 1'b0, sdd_pkg::DIR_NONE};
    rows[3]  = '{100, 100, 100, 100, 1'b1, 1'b1, sdd_pkg::DIR_NONE};
    rows[4]  = '{200,  40, 120, 120, 1'b0, 1'b0, sdd_pkg::DIR_NONE};
    rows[5]  = '{ 40, 200, 120, 120, 1'b1, 1'b0, sdd_pkg::DIR_NONE};
    rows[6]  = '{ 40, 200, 120, 120, 1'b0, 1'b0, sdd_pkg::DIR_NONE};
    rows[7]  = '{200,  40, 120, 120, 1'b1, 1'b0, sdd_pkg::DIR_NONE};
    rows[8]  = '{120, 120, 200,  40, 1'b0, 1'b0, sdd_pkg::DIR_NONE};
    rows[9]  = '{120, 120,  40, 200, 1'b1, 1'b0, sdd_pkg::DIR_NONE};
    rows[10] = '{120, 120,  40, 200, 1'b0, 1'b0, sdd_pkg::DIR_NONE};
    rows[11] = '{254, 254, 254, 254, 1'b0, 1'b0, sdd_pkg::DIR_NONE};
    rows[12] = '{120, 120, 200,  40, 1'b1, 1'b0, sdd_pkg::DIR_NONE};
    rows[13] = '{ 30, 254, 254,  30, 1'b0, 1'b0, sdd_pkg::DIR_NONE};
    rows[14] = '{254,  30,  30, 254, 1'b0, 1'b0, sdd_pkg::DIR_NONE};
    rows[15] = '{100, 100, 100, 255, 1'b1, 1'b0, sdd_pkg::DIR_NONE};
    rows[16] = '{ 30,  30,  30,  30, 1'b0, 1'b0, sdd_pkg::DIR_NONE};
    rows[17] = '{ 30,  30,  30,  30, 1'b1, 1'b0, sdd_pkg::DIR_NONE};
    rows[18] = '{  0,   0,   0,   0, 1'b0, 1'b0, sdd_pkg::DIR_NONE};
    rows[19] = '{  0,   0,   0,   0, 1'b1, 1'b0, sdd_pkg::DIR_NONE};
    rows[20] = '{  0, 255,   0,   0, 1'b0, 1'b0, sdd_pkg::DIR_NONE};
    rows[21] = '{  5,   0,   0,   0, 1'b1, 1'b1, sdd_pkg::DIR_NONE};
    rows[22] = '{255, 255, 255, 255, 1'b1, 1'b1, sdd_pkg::DIR_NONE};
    rows[23] = '{254, 254, 254, 254, 1'b0, 1'b0, sdd_pkg::DIR_NONE};
    rows[24] = '{254, 254, 254, 254, 1'b1, 1'b1, sdd_pkg::DIR_NONE};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_ROWS; i++) begin
      // Zero threshold and level expose the zero-sum and zero-delta cases; a level of
      // 255 then leaves no sample able to count.
      if (i == ROW_LOOSE_CFG) begin
        quiesce();
        program_regs(0, 0);
      end
      if (i == ROW_DARK_CFG) begin
        quiesce();
        program_regs(100, 255);
      end
      push_item(rows[i].up, rows[i].down, rows[i].left, rows[i].right,
                rows[i].eog, rows[i].typed, rows[i].dir);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 59; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 59; end
        default: begin send_idle = 22; recv_stall = 22; end
      endcase
      if (p == NUM_PHASES - 1) begin
        phase_thr[p] = $urandom_range(0, 100);
        phase_min[p] = $urandom_range(0, 120);
      end
      program_regs(phase_thr[p], phase_min[p]);
      start = items_sent;
      while (items_sent - start < ITEMS_PER_PHASE) begin
        random_gesture();
        // Now and then hold the next item back until every direction is out.
        if ($urandom_range(0, 29) == 0) wait_results();
      end
    end

    quiesce();
    if (pending_dirs.size() != 0)
      report_mismatch($sformatf("%0d directions never arrived", pending_dirs.size()));
    $display("Ran %0d items forming %0d gestures, with %0d register writes over %0d settings.",
             items_sent, gestures, cfg_writes, NUM_PHASES + 3);
    $display("Directions out: none %0d, up %0d, down %0d, left %0d, right %0d; %0d mismatches.",
             dir_count[0], dir_count[1], dir_count[2], dir_count[3], dir_count[4], mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
